FILE: rtl/spcao_pkg.sv
`timescale 1ns / 1ps
// spcao_pkg: state type, command/status/register codes and datapath widths
// for the servo pulse command block. No dependencies.
package spcao_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV,
        ST_QFIX,
        ST_PULSE,
        ST_CLAMP,
        ST_SAT,
        ST_DONE
    } state_t;

    // commands
    localparam logic [2:0] CMD_CHECKED = 3'd0;
    localparam logic [2:0] CMD_RATIO   = 3'd1;
    localparam logic [2:0] CMD_PULSE   = 3'd2;
    localparam logic [2:0] CMD_TICK    = 3'd3;
    localparam logic [2:0] CMD_START   = 3'd4;
    localparam logic [2:0] CMD_READ    = 3'd5;

    // result status
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_RANGE       = 2'd1;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_RATIO_MODE   = 3'd0;
    localparam logic [2:0] REG_MIN_VALUE    = 3'd1;
    localparam logic [2:0] REG_MAX_VALUE    = 3'd2;
    localparam logic [2:0] REG_MIN_PULSE    = 3'd3;
    localparam logic [2:0] REG_MAX_PULSE    = 3'd4;
    localparam logic [2:0] REG_START_PULSE  = 3'd5;
    localparam logic [2:0] REG_PULSE_OFFSET = 3'd6;
    localparam logic [2:0] REG_AUTO_OFF_MS  = 3'd7;

    // register reset values
    localparam logic [31:0] RST_MIN_VALUE   = 32'd0;
    localparam logic [31:0] RST_MAX_VALUE   = 32'd65536;
    localparam logic [15:0] RST_MIN_PULSE   = 16'd1000;
    localparam logic [15:0] RST_MAX_PULSE   = 16'd2000;
    localparam logic [15:0] RST_START_PULSE = 16'd1500;

    // datapath widths
    localparam int unsigned MAG_W     = 32;             // |value - min_value|, divisor
    localparam int unsigned SPAN_W    = 16;             // |max_pulse - min_pulse|
    localparam int unsigned WORK_W    = MAG_W + SPAN_W; // product / dividend / quotient
    localparam int unsigned Q_W       = WORK_W + 2;     // signed floor quotient
    localparam int unsigned PULSE_W   = Q_W + 1;        // signed pulse before saturation
    localparam int unsigned BASE_W    = 18;             // 16-bit pulse plus signed trim
    localparam int unsigned PC_W      = 17;             // clamped pulse, up to PERIOD_US + 1
    localparam int unsigned MUL_STEPS = SPAN_W;
    localparam int unsigned DIV_STEPS = WORK_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

endpackage

FILE: rtl/servo_pulse_command_with_auto_off.sv
`timescale 1ns / 1ps
// servo_pulse_command_with_auto_off: servo command decoder, bit-serial
// ratio mapping and duty scaling, auto-off timer. Depends on spcao_pkg.

// One request in, one result out. Writes turn a signed Q16.16 value (ratio
// mode) or a pulse width in microseconds into a PWM compare value; ticks count
// milliseconds since the last write and switch the drive off once the count
// passes auto_off_ms. All arithmetic runs through one shift-add multiplier
// (16 steps, one bit a cycle) and one restoring divider (48 steps, one
// quotient bit a cycle). Tick, read, rejected and unsupported requests go
// from decode straight to completion; pulse-mode writes, unchecked pulse
// writes, start, and ratio writes over an empty value range make one
// multiply/divide pass for the duty scaling; ratio writes over a nonempty
// value range make a mapping pass plus the duty pass.
// A new request can be taken in the cycle after the previous result is loaded
// into the output register, which holds it until the sink takes it.
module servo_pulse_command_with_auto_off #(
    parameter int unsigned DUTY_MAX  = 65535,
    parameter int unsigned PERIOD_US = 20000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] value, [47:32] pulse_us
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [1:0] status, [17:2] duty, [49:18] last_value
    output logic        m_tuser,   // [0] drive_update
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned MAG_W   = spcao_pkg::MAG_W;
    localparam int unsigned SPAN_W  = spcao_pkg::SPAN_W;
    localparam int unsigned WORK_W  = spcao_pkg::WORK_W;
    localparam int unsigned Q_W     = spcao_pkg::Q_W;
    localparam int unsigned PULSE_W = spcao_pkg::PULSE_W;
    localparam int unsigned BASE_W  = spcao_pkg::BASE_W;
    localparam int unsigned PC_W    = spcao_pkg::PC_W;
    localparam int unsigned CNT_W   = spcao_pkg::CNT_W;

    localparam logic [15:0]       DUTY_MAX_C  = 16'(DUTY_MAX);
    localparam logic [PC_W-1:0]   PC_LIMIT    = PC_W'(PERIOD_US + 1);
    localparam logic [MAG_W-1:0]  PERIOD_C    = MAG_W'(PERIOD_US);
    localparam logic [CNT_W-1:0]  MUL_LAST    = CNT_W'(spcao_pkg::MUL_STEPS - 1);
    localparam logic [CNT_W-1:0]  DIV_LAST    = CNT_W'(spcao_pkg::DIV_STEPS - 1);

    // ---------------- configuration registers ----------------
    logic        ratio_mode_reg;
    logic [31:0] min_value_reg;
    logic [31:0] max_value_reg;
    logic [15:0] min_pulse_reg;
    logic [15:0] max_pulse_reg;
    logic [15:0] start_pulse_reg;
    logic [15:0] pulse_offset_reg;
    logic [31:0] auto_off_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_mode_reg   <= 1'b0;
            min_value_reg    <= spcao_pkg::RST_MIN_VALUE;
            max_value_reg    <= spcao_pkg::RST_MAX_VALUE;
            min_pulse_reg    <= spcao_pkg::RST_MIN_PULSE;
            max_pulse_reg    <= spcao_pkg::RST_MAX_PULSE;
            start_pulse_reg  <= spcao_pkg::RST_START_PULSE;
            pulse_offset_reg <= 16'd0;
            auto_off_reg     <= 32'd0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                spcao_pkg::REG_RATIO_MODE:   ratio_mode_reg   <= pwdata[0];
                spcao_pkg::REG_MIN_VALUE:    min_value_reg    <= pwdata;
                spcao_pkg::REG_MAX_VALUE:    max_value_reg    <= pwdata;
                spcao_pkg::REG_MIN_PULSE:    min_pulse_reg    <= pwdata[15:0];
                spcao_pkg::REG_MAX_PULSE:    max_pulse_reg    <= pwdata[15:0];
                spcao_pkg::REG_START_PULSE:  start_pulse_reg  <= pwdata[15:0];
                spcao_pkg::REG_PULSE_OFFSET: pulse_offset_reg <= pwdata[15:0];
                spcao_pkg::REG_AUTO_OFF_MS:  auto_off_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            spcao_pkg::REG_RATIO_MODE:   prdata = {31'd0, ratio_mode_reg};
            spcao_pkg::REG_MIN_VALUE:    prdata = min_value_reg;
            spcao_pkg::REG_MAX_VALUE:    prdata = max_value_reg;
            spcao_pkg::REG_MIN_PULSE:    prdata = {16'd0, min_pulse_reg};
            spcao_pkg::REG_MAX_PULSE:    prdata = {16'd0, max_pulse_reg};
            spcao_pkg::REG_START_PULSE:  prdata = {16'd0, start_pulse_reg};
            spcao_pkg::REG_PULSE_OFFSET: prdata = {{16{pulse_offset_reg[15]}}, pulse_offset_reg};
            spcao_pkg::REG_AUTO_OFF_MS:  prdata = auto_off_reg;
            default:                     prdata = 32'd0;
        endcase
    end

    // ---------------- state ----------------
    spcao_pkg::state_t state_reg, state_next;

    logic [2:0]  cmd_reg;
    logic [31:0] value_reg;
    logic [15:0] pus_reg;

    logic        armed_reg, armed_next;
    logic [31:0] ms_reg, ms_next;
    logic [31:0] stored_reg, stored_next;

    logic [1:0]  status_reg, status_next;
    logic        upd_reg, upd_next;
    logic [15:0] duty_reg, duty_next;

    logic                     pass_reg, pass_next;   // 0 ratio mapping, 1 duty scaling
    logic                     neg_reg, neg_next;     // sign of the mapping product
    logic [MAG_W-1:0]         mcand_reg, mcand_next;
    logic [MAG_W-1:0]         dsor_reg, dsor_next;
    logic [WORK_W-1:0]        work_reg, work_next;
    logic [MAG_W-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [BASE_W-1:0] base_reg, base_next;
    logic signed [Q_W-1:0]    q_reg, q_next;
    logic signed [PULSE_W-1:0] pulse_reg, pulse_next;

    logic        m_tvalid_reg;
    logic [1:0]  m_status_reg;
    logic        m_upd_reg;
    logic [15:0] m_duty_reg;
    logic [31:0] m_last_reg;
    logic        out_free;

    assign s_tready = (state_reg == spcao_pkg::ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- decode ----------------
    logic signed [32:0] v_x, lo_x, hi_x, dv_up, dv_dn, den_full;
    logic               v_lt_lo, v_gt_hi, den_pos, span_neg;
    logic [MAG_W-1:0]   dv_mag;
    logic [SPAN_W-1:0]  span_mag;
    logic               cmd_chk, cmd_ratio, cmd_pulse, cmd_tick, cmd_start, unsupported;
    logic               ratio_ok, pulse_ok, chk_ok, chk_bad, use_map, use_div;
    logic               wrote, has_pulse, tick_off;
    logic [BASE_W-1:0]  base_a, base_b, offset_x;

    assign v_x      = {value_reg[31], value_reg};
    assign lo_x     = {min_value_reg[31], min_value_reg};
    assign hi_x     = {max_value_reg[31], max_value_reg};
    assign v_lt_lo  = v_x < lo_x;
    assign v_gt_hi  = v_x > hi_x;
    assign den_pos  = hi_x > lo_x;
    assign dv_up    = v_x - lo_x;
    assign dv_dn    = lo_x - v_x;
    assign den_full = hi_x - lo_x;
    assign dv_mag   = v_lt_lo ? dv_dn[MAG_W-1:0] : dv_up[MAG_W-1:0];
    assign span_neg = max_pulse_reg < min_pulse_reg;
    assign span_mag = span_neg ? (min_pulse_reg - max_pulse_reg)
                               : (max_pulse_reg - min_pulse_reg);

    assign cmd_chk     = (cmd_reg == spcao_pkg::CMD_CHECKED);
    assign cmd_ratio   = (cmd_reg == spcao_pkg::CMD_RATIO);
    assign cmd_pulse   = (cmd_reg == spcao_pkg::CMD_PULSE);
    assign cmd_tick    = (cmd_reg == spcao_pkg::CMD_TICK);
    assign cmd_start   = (cmd_reg == spcao_pkg::CMD_START);
    assign unsupported = (cmd_reg > spcao_pkg::CMD_READ);

    assign ratio_ok  = !v_lt_lo && !v_gt_hi;
    assign pulse_ok  = (pus_reg >= min_pulse_reg) && (pus_reg <= max_pulse_reg);
    assign chk_ok    = cmd_chk && (ratio_mode_reg ? ratio_ok : pulse_ok);
    assign chk_bad   = cmd_chk && !chk_ok;
    assign use_map   = (cmd_chk && ratio_mode_reg && ratio_ok) || cmd_ratio;
    assign use_div   = use_map && den_pos;
    assign wrote     = chk_ok || cmd_ratio || cmd_pulse;
    assign has_pulse = wrote || cmd_start;
    // count after increment exceeds the limit; a saturated count never exceeds all ones
    assign tick_off  = cmd_tick && armed_reg && (ms_reg >= auto_off_reg)
                       && !((&ms_reg) && (&auto_off_reg));

    // base pulse before the quotient: min_pulse, pulse_us or start_pulse, plus trim on checked and start requests
    assign offset_x = {{2{pulse_offset_reg[15]}}, pulse_offset_reg};
    assign base_a   = use_map   ? {2'b00, min_pulse_reg}
                    : cmd_start ? {2'b00, start_pulse_reg}
                    :             {2'b00, pus_reg};
    assign base_b   = (cmd_chk || cmd_start) ? offset_x : '0;

    // ---------------- serial units ----------------
    logic [MAG_W:0]   mul_sum, div_t, div_diff;
    logic             div_ge;
    logic [Q_W-1:0]   qext;
    logic             pulse_pos, pulse_big;
    logic [PC_W-1:0]  pc;

    assign mul_sum  = {1'b0, work_reg[WORK_W-1:SPAN_W]} + {1'b0, mcand_reg};
    assign div_t    = {rem_reg, work_reg[WORK_W-1]};
    assign div_diff = div_t - {1'b0, dsor_reg};
    assign div_ge   = div_t >= {1'b0, dsor_reg};
    assign qext     = {2'b00, work_reg};

    assign pulse_pos = !pulse_reg[PULSE_W-1] && (pulse_reg != '0);
    assign pulse_big = pulse_reg[PULSE_W-2:0] > (PULSE_W-1)'(PERIOD_US);
    assign pc        = !pulse_pos ? '0 : (pulse_big ? PC_LIMIT : pulse_reg[PC_W-1:0]);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spcao_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = spcao_pkg::ST_DECODE;
            end
            spcao_pkg::ST_DECODE: begin
                if (use_div)        state_next = spcao_pkg::ST_MUL;
                else if (has_pulse) state_next = spcao_pkg::ST_PULSE;
                else                state_next = spcao_pkg::ST_DONE;
            end
            spcao_pkg::ST_MUL: begin
                if (cnt_reg == MUL_LAST) state_next = spcao_pkg::ST_DIV;
            end
            spcao_pkg::ST_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = pass_reg ? spcao_pkg::ST_SAT : spcao_pkg::ST_QFIX;
                end
            end
            spcao_pkg::ST_QFIX:  state_next = spcao_pkg::ST_PULSE;
            spcao_pkg::ST_PULSE: state_next = spcao_pkg::ST_CLAMP;
            spcao_pkg::ST_CLAMP: state_next = spcao_pkg::ST_MUL;
            spcao_pkg::ST_SAT:   state_next = spcao_pkg::ST_DONE;
            spcao_pkg::ST_DONE: begin
                if (out_free) state_next = spcao_pkg::ST_IDLE;
            end
            default: state_next = spcao_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    always_comb begin
        armed_next  = armed_reg;
        ms_next     = ms_reg;
        stored_next = stored_reg;
        status_next = status_reg;
        upd_next    = upd_reg;
        duty_next   = duty_reg;
        pass_next   = pass_reg;
        neg_next    = neg_reg;
        mcand_next  = mcand_reg;
        dsor_next   = dsor_reg;
        work_next   = work_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        base_next   = base_reg;
        q_next      = q_reg;
        pulse_next  = pulse_reg;
        unique case (state_reg)
            spcao_pkg::ST_DECODE: begin
                if (unsupported)  status_next = spcao_pkg::STATUS_UNSUPPORTED;
                else if (chk_bad) status_next = spcao_pkg::STATUS_RANGE;
                else              status_next = spcao_pkg::STATUS_OK;
                upd_next   = has_pulse || tick_off;
                duty_next  = 16'd0;
                base_next  = $signed(base_a + base_b);
                q_next     = '0;
                mcand_next = dv_mag;
                work_next  = {{MAG_W{1'b0}}, span_mag};
                dsor_next  = den_full[MAG_W-1:0];
                neg_next   = v_lt_lo ^ span_neg;
                pass_next  = 1'b0;
                cnt_next   = '0;
                if (wrote) begin
                    ms_next = 32'd0;
                    if (auto_off_reg != 32'd0) armed_next = 1'b1;
                end
                if (chk_ok) begin
                    stored_next = ratio_mode_reg ? value_reg : {pus_reg, 16'd0};
                end
                if (cmd_tick && armed_reg) begin
                    if (!(&ms_reg)) ms_next = ms_reg + 32'd1;
                    if (tick_off) armed_next = 1'b0;
                end
            end
            spcao_pkg::ST_MUL: begin
                work_next = work_reg[0] ? {mul_sum, work_reg[SPAN_W-1:1]}
                                        : {1'b0, work_reg[WORK_W-1:1]};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == MUL_LAST) begin
                    cnt_next = '0;
                    rem_next = '0;
                end
            end
            spcao_pkg::ST_DIV: begin
                rem_next  = div_ge ? div_diff[MAG_W-1:0] : div_t[MAG_W-1:0];
                work_next = {work_reg[WORK_W-2:0], div_ge};
                cnt_next  = (cnt_reg == DIV_LAST) ? '0 : cnt_reg + CNT_W'(1);
            end
            spcao_pkg::ST_QFIX: begin
                // floor for a negative product: -(q + (rem != 0))
                q_next = neg_reg ? $signed(~qext + Q_W'(!(|rem_reg))) : $signed(qext);
            end
            spcao_pkg::ST_PULSE: begin
                pulse_next = $signed({q_reg[Q_W-1], q_reg}
                             + {{(PULSE_W-BASE_W){base_reg[BASE_W-1]}}, base_reg});
            end
            spcao_pkg::ST_CLAMP: begin
                mcand_next = {{(MAG_W-PC_W){1'b0}}, pc};
                work_next  = {{MAG_W{1'b0}}, DUTY_MAX_C};
                dsor_next  = PERIOD_C;
                pass_next  = 1'b1;
                cnt_next   = '0;
            end
            spcao_pkg::ST_SAT: begin
                duty_next = (work_reg > WORK_W'(DUTY_MAX)) ? DUTY_MAX_C : work_reg[15:0];
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= spcao_pkg::ST_IDLE;
            armed_reg    <= 1'b0;
            ms_reg       <= 32'd0;
            stored_reg   <= 32'd0;
            cnt_reg      <= '0;
            pass_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            armed_reg  <= armed_next;
            ms_reg     <= ms_next;
            stored_reg <= stored_next;
            cnt_reg    <= cnt_next;
            pass_reg   <= pass_next;
            if (state_reg == spcao_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg   <= s_tuser;
            value_reg <= s_tdata[31:0];
            pus_reg   <= s_tdata[47:32];
        end
        status_reg <= status_next;
        upd_reg    <= upd_next;
        duty_reg   <= duty_next;
        neg_reg    <= neg_next;
        mcand_reg  <= mcand_next;
        dsor_reg   <= dsor_next;
        work_reg   <= work_next;
        rem_reg    <= rem_next;
        base_reg   <= base_next;
        q_reg      <= q_next;
        pulse_reg  <= pulse_next;
        if (state_reg == spcao_pkg::ST_DONE && out_free) begin
            m_status_reg <= status_reg;
            m_upd_reg    <= upd_reg;
            m_duty_reg   <= duty_reg;
            m_last_reg   <= stored_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_last_reg, m_duty_reg, m_status_reg};
    assign m_tuser  = m_upd_reg;

`ifndef NO_ASSERTIONS
    // a result is only loaded out of the completion state
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == spcao_pkg::ST_DONE))
        else $error("result loaded outside completion state");

    // without a drive update the compare value is zero
    a_duty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[17:2] == 16'd0))
        else $error("duty nonzero without drive update");

    // rejected or unsupported requests never update the drive
    a_bad_no_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != spcao_pkg::STATUS_OK)) |-> !m_tuser)
        else $error("drive update on failed request");

    // no request is taken while a serial pass is running
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == spcao_pkg::ST_MUL || state_reg == spcao_pkg::ST_DIV) |-> !s_tready)
        else $error("ready while busy");
`endif

endmodule
